>>> hdl/arpc_pkg.sv
// Shared types and constants for the ARP cache and responder core.
// Used by the controller, the datapath and the top level; depends on nothing.
package arpc_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Function codes of an input word.
  localparam logic [1:0] FUNC_PKT   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_ADD   = 2'd2;
  localparam logic [1:0] FUNC_RSVD  = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_HIT   = 3'd1;
  localparam logic [2:0] KIND_REQ   = 3'd2;
  localparam logic [2:0] KIND_REPLY = 3'd3;
  localparam logic [2:0] KIND_DROP  = 3'd4;

  // Packet checks.
  localparam logic [15:0] ARP_MIN_LEN    = 16'd28;
  localparam logic [15:0] HW_ETHERNET    = 16'd1;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [15:0] OPCODE_REQUEST = 16'd1;

  // Operation of an outgoing frame.
  localparam logic [1:0] FOP_NONE  = 2'd0;
  localparam logic [1:0] FOP_REQ   = 2'd1;
  localparam logic [1:0] FOP_REPLY = 2'd2;

  localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes.
  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic start;     // capture the input word, restart the scan
    logic scan;      // step the table scan
    logic write;     // write the learnt binding
    logic load_out;  // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;      // word needs no table access
    logic learn;     // word teaches the table a binding
    logic scan_done; // last entry compared this cycle
    logic out_free;  // result register can take a word
  } dp_status_t;

endpackage

>>> hdl/arpc_ctrl.sv
// Controller state machine of the ARP cache and responder core.
// Depends on arpc_pkg; drives the datapath through ctrl_cmd_t.
module arpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  arpc_pkg::dp_status_t status_i,
  output arpc_pkg::ctrl_cmd_t  cmd_o
);

  arpc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      arpc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = arpc_pkg::ST_SCAN;
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (status_i.skip) begin
          state_d = arpc_pkg::ST_DONE;
        end else begin
          cmd_o.scan = 1'b1;
          if (status_i.scan_done) begin
            state_d = status_i.learn ? arpc_pkg::ST_WRITE : arpc_pkg::ST_DONE;
          end
        end
      end
      arpc_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = arpc_pkg::ST_DONE;
      end
      arpc_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = arpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != arpc_pkg::ST_IDLE);

endmodule

>>> hdl/arpc_dpath.sv
// Datapath of the ARP cache and responder core: table memory, scan, result register.
// Depends on arpc_pkg; commanded by arpc_ctrl.
module arpc_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  arpc_pkg::ctrl_cmd_t  cmd_i,
  output arpc_pkg::dp_status_t status_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [47:0]          cfg_wdata_i,
  input  logic [1:0]           func_i,
  input  logic [15:0]          pkt_len_i,
  input  logic [15:0]          hw_type_i,
  input  logic [15:0]          proto_type_i,
  input  logic [15:0]          arp_op_i,
  input  logic [47:0]          sender_mac_i,
  input  logic [31:0]          sender_ip_i,
  input  logic [31:0]          target_ip_i,
  input  logic [31:0]          query_ip_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           result_kind_o,
  output logic [47:0]          resolved_mac_o,
  output logic [47:0]          frame_dest_mac_o,
  output logic [1:0]           frame_op_o,
  output logic [47:0]          frame_target_mac_o,
  output logic [31:0]          frame_target_ip_o
);

  localparam int unsigned N = arpc_pkg::TABLE_ENTRIES;
  localparam int unsigned W = arpc_pkg::IDX_W;

  logic [31:0] ip_mem  [N];
  logic [47:0] mac_mem [N];
  logic [N-1:0] valid_q;

  logic [31:0] own_ip_q;

  logic [1:0]  func_q;
  logic [31:0] key_q;
  logic [47:0] mac_q;
  logic        drop_q, reply_q;

  logic [W-1:0] addr_q, cmp_idx_q, hit_idx_q, empty_idx_q, wr_idx;
  logic         issued_all_q, cmp_act_q, hit_q, empty_found_q;
  logic [31:0]  ip_rd_q;
  logic [47:0]  mac_rd_q, hit_mac_q;
  logic         match, cmp_valid;

  logic        out_valid_q;
  logic [2:0]  kind_d;
  logic [47:0] res_mac_d, dest_mac_d, tmac_d;
  logic [1:0]  fop_d;
  logic [31:0] tip_d;

  // Only own_ip shapes a result; own_mac is not stored here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        arpc_pkg::CFG_OWN_IP:  own_ip_q <= cfg_wdata_i[31:0];
        arpc_pkg::CFG_OWN_MAC: own_ip_q <= own_ip_q;
        default:               own_ip_q <= own_ip_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q  <= func_i;
      key_q   <= (func_i == arpc_pkg::FUNC_QUERY) ? query_ip_i : sender_ip_i;
      mac_q   <= sender_mac_i;
      drop_q  <= (pkt_len_i < arpc_pkg::ARP_MIN_LEN) || (hw_type_i != arpc_pkg::HW_ETHERNET)
                 || (proto_type_i != arpc_pkg::PROTO_IPV4);
      reply_q <= (arp_op_i == arpc_pkg::OPCODE_REQUEST) && (target_ip_i == own_ip_q);
    end
  end

  assign cmp_valid = valid_q[cmp_idx_q];
  assign match     = cmp_act_q && cmp_valid && (ip_rd_q == key_q);
  assign wr_idx    = hit_q ? hit_idx_q : (empty_found_q ? empty_idx_q : '0);

  // Table memory: one write port, one registered read port driven by the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      ip_mem[wr_idx]  <= key_q;
      mac_mem[wr_idx] <= mac_q;
    end
    ip_rd_q  <= ip_mem[addr_q];
    mac_rd_q <= mac_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= addr_q;
    if (match && !hit_q) begin
      hit_idx_q <= cmp_idx_q;
      hit_mac_q <= mac_rd_q;
    end
    if (cmp_act_q && !cmp_valid && !empty_found_q) begin
      empty_idx_q <= cmp_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      addr_q        <= '0;
      issued_all_q  <= 1'b0;
      cmp_act_q     <= 1'b0;
      hit_q         <= 1'b0;
      empty_found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        addr_q        <= '0;
        issued_all_q  <= 1'b0;
        cmp_act_q     <= 1'b0;
        hit_q         <= 1'b0;
        empty_found_q <= 1'b0;
      end else begin
        cmp_act_q <= cmd_i.scan && !issued_all_q;
        if (cmd_i.scan && !issued_all_q) begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == arpc_pkg::LAST_IDX) begin
            issued_all_q <= 1'b1;
          end
        end
        if (match) begin
          hit_q <= 1'b1;
        end
        if (cmp_act_q && !cmp_valid) begin
          empty_found_q <= 1'b1;
        end
      end
      if (cmd_i.write) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  always_comb begin
    kind_d     = arpc_pkg::KIND_NONE;
    res_mac_d  = '0;
    dest_mac_d = '0;
    fop_d      = arpc_pkg::FOP_NONE;
    tmac_d     = '0;
    tip_d      = '0;
    case (func_q)
      arpc_pkg::FUNC_PKT: begin
        if (drop_q) begin
          kind_d = arpc_pkg::KIND_DROP;
        end else if (reply_q) begin
          kind_d     = arpc_pkg::KIND_REPLY;
          dest_mac_d = mac_q;
          fop_d      = arpc_pkg::FOP_REPLY;
          tmac_d     = mac_q;
          tip_d      = key_q;
        end
      end
      arpc_pkg::FUNC_QUERY: begin
        if (hit_q) begin
          kind_d    = arpc_pkg::KIND_HIT;
          res_mac_d = hit_mac_q;
        end else begin
          kind_d     = arpc_pkg::KIND_REQ;
          dest_mac_d = arpc_pkg::BROADCAST_MAC;
          fop_d      = arpc_pkg::FOP_REQ;
          tip_d      = key_q;
        end
      end
      default: begin
        kind_d = arpc_pkg::KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      result_kind_o      <= kind_d;
      resolved_mac_o     <= res_mac_d;
      frame_dest_mac_o   <= dest_mac_d;
      frame_op_o         <= fop_d;
      frame_target_mac_o <= tmac_d;
      frame_target_ip_o  <= tip_d;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.skip      = ((func_q == arpc_pkg::FUNC_PKT) && drop_q)
                              || (func_q == arpc_pkg::FUNC_RSVD);
  assign status_o.learn     = (func_q == arpc_pkg::FUNC_PKT) || (func_q == arpc_pkg::FUNC_ADD);
  assign status_o.scan_done = cmp_act_q && (cmp_idx_q == arpc_pkg::LAST_IDX);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result register loaded while a word is still waiting");

  a_hit_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> valid_q[hit_idx_q])
    else $error("recorded hit points at an empty entry");

  a_write_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> (!cmp_act_q && issued_all_q))
    else $error("table written before the scan finished");

  a_scan_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmp_act_q && $past(cmp_act_q) && !$past(cmd_i.start)) |->
      (cmp_idx_q == $past(cmp_idx_q) + 1'b1))
    else $error("scan skipped or repeated an entry");

endmodule

>>> hdl/arp_cache_and_responder_core.sv
// ARP cache and responder core: top level joining controller and datapath.
// A result word is offered after its input word is scanned against the table, written
// into it when the word teaches a binding, and loaded; a dropped packet or the unused
// function code skips the scan. One word is in flight at a time: the next is taken in
// the cycle after the result is loaded; the scan reads 16 entries via a single read port.
// Reset (asynchronous, active low) clears the entry valid bits, own_ip and the handshakes.
module arp_cache_and_responder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [47:0] cfg_wdata_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] pkt_len_i,
  input  logic [15:0] hw_type_i,
  input  logic [15:0] proto_type_i,
  input  logic [15:0] arp_op_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] sender_ip_i,
  input  logic [31:0] target_ip_i,
  input  logic [31:0] query_ip_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [47:0] resolved_mac_o,
  output logic [47:0] frame_dest_mac_o,
  output logic [1:0]  frame_op_o,
  output logic [47:0] frame_target_mac_o,
  output logic [31:0] frame_target_ip_o
);

  // The controller walks each word through scan, optional table write and result load.
  // The datapath holds the table, the captured word, the scan pipeline and the result
  // register, so a finished word can wait at the output while the next one is taken in.
  arpc_pkg::ctrl_cmd_t  cmd;
  arpc_pkg::dp_status_t status;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Learning updates a matching valid entry, else fills the lowest empty slot, else
  // evicts slot zero; the scan records both the first match and the first empty slot.
  arpc_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .func_i             (func_i),
    .pkt_len_i          (pkt_len_i),
    .hw_type_i          (hw_type_i),
    .proto_type_i       (proto_type_i),
    .arp_op_i           (arp_op_i),
    .sender_mac_i       (sender_mac_i),
    .sender_ip_i        (sender_ip_i),
    .target_ip_i        (target_ip_i),
    .query_ip_i         (query_ip_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .resolved_mac_o     (resolved_mac_o),
    .frame_dest_mac_o   (frame_dest_mac_o),
    .frame_op_o         (frame_op_o),
    .frame_target_mac_o (frame_target_mac_o),
    .frame_target_ip_o  (frame_target_ip_o)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the ARP cache and responder core.
// Needs arpc_pkg and arp_cache_and_responder_core. It keeps its own copy of the binding
// table, predicts every result word and compares each one field by field.
`timescale 1ns / 100ps

module testbench;

  // Opcode of an ARP reply as it appears in a received word. The package names only
  // the request opcode.
  localparam logic [15:0] OPCODE_REPLY = 16'd2;
  localparam int ADDR_POOL  = 24;   // more addresses than entries, so slot 0 gets evicted
  localparam int LONG_HOLD  = 300;  // cycles for which the receiver holds off once
  localparam int MAX_SHOWN  = 10;
  localparam int TAIL_WAIT  = 40;   // idle cycles after the final drain

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] pkt_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] arp_op;
    logic [47:0] sender_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] query_ip;
  } arp_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] resolved_mac;
    logic [47:0] dest_mac;
    logic [1:0]  op;
    logic [47:0] target_mac;
    logic [31:0] tgt_ip;
  } arp_result_t;

  // Shadow of the binding table and own_ip. Every accepted input word yields exactly one
  // result word, so the awaited results form a plain queue in arrival order.
  class arp_scoreboard;
    bit          bind_valid [arpc_pkg::TABLE_ENTRIES];
    bit [31:0]   bind_ip    [arpc_pkg::TABLE_ENTRIES];
    bit [47:0]   bind_mac   [arpc_pkg::TABLE_ENTRIES];
    bit [31:0]   own_ip;
    arp_result_t awaited [$];
    int unsigned errors, words, hits, requests, replies, drops, evictions, reg_writes;

    function int find_binding(bit [31:0] ip);
      for (int i = 0; i < arpc_pkg::TABLE_ENTRIES; i++)
        if (bind_valid[i] && bind_ip[i] == ip) return i;
      return -1;
    endfunction

    // A known address only has its MAC refreshed; a new one takes the lowest free slot,
    // or slot 0 once the table is full.
    function void learn_binding(bit [31:0] ip, bit [47:0] mac);
      int slot;
      slot = find_binding(ip);
      if (slot < 0) begin
        slot = 0;
        while (slot < arpc_pkg::TABLE_ENTRIES && bind_valid[slot]) slot++;
        if (slot == arpc_pkg::TABLE_ENTRIES) begin
          slot = 0;
          evictions++;
        end
        bind_valid[slot] = 1'b1;
        bind_ip[slot]    = ip;
      end
      bind_mac[slot] = mac;
    endfunction

    function void write_reg(logic idx, logic [47:0] data);
      if (idx == arpc_pkg::CFG_OWN_IP) own_ip = data[31:0];
      reg_writes++;
    endfunction

    // Works out the result of an accepted word and queues it.
    function void predict_outcome(arp_word_t w);
      arp_result_t r;
      int slot;
      r = '0;
      r.kind = arpc_pkg::KIND_NONE;
      r.op = arpc_pkg::FOP_NONE;
      case (w.func)
        arpc_pkg::FUNC_PKT: begin
          if (w.pkt_len < arpc_pkg::ARP_MIN_LEN || w.hw_type != arpc_pkg::HW_ETHERNET ||
              w.proto_type != arpc_pkg::PROTO_IPV4) begin
            r.kind = arpc_pkg::KIND_DROP;
            drops++;
          end else begin
            learn_binding(w.src_ip, w.sender_mac);
            if (w.arp_op == arpc_pkg::OPCODE_REQUEST && w.dst_ip == own_ip) begin
              r.kind       = arpc_pkg::KIND_REPLY;
              r.dest_mac   = w.sender_mac;
              r.op         = arpc_pkg::FOP_REPLY;
              r.target_mac = w.sender_mac;
              r.tgt_ip     = w.src_ip;
              replies++;
            end
          end
        end
        arpc_pkg::FUNC_QUERY: begin
          slot = find_binding(w.query_ip);
          if (slot >= 0) begin
            r.kind         = arpc_pkg::KIND_HIT;
            r.resolved_mac = bind_mac[slot];
            hits++;
          end else begin
            r.kind     = arpc_pkg::KIND_REQ;
            r.dest_mac = arpc_pkg::BROADCAST_MAC;
            r.op       = arpc_pkg::FOP_REQ;
            r.tgt_ip   = w.query_ip;
            requests++;
          end
        end
        arpc_pkg::FUNC_ADD: learn_binding(w.src_ip, w.sender_mac);
        default: ;
      endcase
      awaited.push_back(r);
      words++;
    endfunction

    function void mismatch(string what, logic [47:0] want, logic [47:0] got);
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    endfunction

    function void compare_field(string what, logic [47:0] want, logic [47:0] got);
      if (want !== got) mismatch(what, want, got);
    endfunction

    function void check_outcome(arp_result_t got);
      arp_result_t want;
      if (awaited.size() == 0) begin
        mismatch("result word with nothing awaited, kind", '0, 48'(got.kind));
        return;
      end
      want = awaited.pop_front();
      compare_field("result_kind", 48'(want.kind), 48'(got.kind));
      compare_field("resolved_mac", want.resolved_mac, got.resolved_mac);
      compare_field("frame_dest_mac", want.dest_mac, got.dest_mac);
      compare_field("frame_op", 48'(want.op), 48'(got.op));
      compare_field("frame_target_mac", want.target_mac, got.target_mac);
      compare_field("frame_target_ip", 48'(want.tgt_ip), 48'(got.tgt_ip));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [47:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [15:0] pkt_len_i, hw_type_i, proto_type_i, arp_op_i;
  logic [47:0] sender_mac_i;
  logic [31:0] sender_ip_i, target_ip_i, query_ip_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  result_kind_o;
  logic [47:0] resolved_mac_o, frame_dest_mac_o, frame_target_mac_o;
  logic [1:0]  frame_op_o;
  logic [31:0] frame_target_ip_o;

  arp_scoreboard sb = new();
  bit [31:0] addr_pool [ADDR_POOL];
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_requested;   // raised by the sender, served and cleared by the receiver

  always #5 clk_i = ~clk_i;

  arp_cache_and_responder_core u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .pkt_len_i,
    .hw_type_i,
    .proto_type_i,
    .arp_op_i,
    .sender_mac_i,
    .sender_ip_i,
    .target_ip_i,
    .query_ip_i,
    .out_valid_o,
    .out_stall_i,
    .result_kind_o,
    .resolved_mac_o,
    .frame_dest_mac_o,
    .frame_op_o,
    .frame_target_mac_o,
    .frame_target_ip_o
  );

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly addresses from a small pool, so that the table sees hits, refreshes and
  // evictions; now and then an arbitrary one.
  function automatic logic [31:0] pick_addr();
    if ($urandom_range(99) < 85) return addr_pool[$urandom_range(ADDR_POOL - 1)];
    return $urandom;
  endfunction

  function automatic arp_word_t pkt_word(logic [15:0] len, logic [15:0] hw, logic [15:0] proto,
                                         logic [15:0] op, logic [47:0] smac, logic [31:0] sip,
                                         logic [31:0] tip);
    arp_word_t w;
    w = '0;
    w.func       = arpc_pkg::FUNC_PKT;
    w.pkt_len    = len;
    w.hw_type    = hw;
    w.proto_type = proto;
    w.arp_op     = op;
    w.sender_mac = smac;
    w.src_ip     = sip;
    w.dst_ip     = tip;
    return w;
  endfunction

  function automatic arp_word_t query_word(logic [31:0] qip);
    arp_word_t w;
    w = '0;
    w.func     = arpc_pkg::FUNC_QUERY;
    w.query_ip = qip;
    return w;
  endfunction

  function automatic arp_word_t table_word(logic [1:0] func, logic [47:0] smac, logic [31:0] sip);
    arp_word_t w;
    w = pkt_word(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                 arpc_pkg::OPCODE_REQUEST, smac, sip, sip);
    w.func = func;
    return w;
  endfunction

  // Most words are well formed with random content, so they get past the packet checks
  // and work the table; about one in seven is noise over the full range of every field.
  function automatic arp_word_t random_word();
    arp_word_t w;
    bit        noisy;
    int        pick;
    noisy = ($urandom_range(99) < 15);
    pick  = $urandom_range(99);
    if (noisy) begin
      w.func       = 2'($urandom_range(3));
      w.pkt_len    = 16'($urandom);
      w.hw_type    = $urandom_range(1) ? arpc_pkg::HW_ETHERNET : 16'($urandom);
      w.proto_type = $urandom_range(1) ? arpc_pkg::PROTO_IPV4 : 16'($urandom);
      w.arp_op     = $urandom_range(1) ? arpc_pkg::OPCODE_REQUEST : 16'($urandom);
    end else begin
      w.func = (pick < 50) ? arpc_pkg::FUNC_PKT : (pick < 85) ? arpc_pkg::FUNC_QUERY :
               (pick < 97) ? arpc_pkg::FUNC_ADD : arpc_pkg::FUNC_RSVD;
      w.pkt_len    = ($urandom_range(15) == 0) ? 16'hFFFF : 16'($urandom_range(1500, 28));
      w.hw_type    = arpc_pkg::HW_ETHERNET;
      w.proto_type = arpc_pkg::PROTO_IPV4;
      pick = $urandom_range(99);
      w.arp_op = (pick < 45) ? arpc_pkg::OPCODE_REQUEST :
                 (pick < 90) ? OPCODE_REPLY : 16'($urandom);
    end
    w.sender_mac = rand_mac();
    w.src_ip     = pick_addr();
    w.dst_ip     = ($urandom_range(99) < 40) ? sb.own_ip : pick_addr();
    w.query_ip   = pick_addr();
    return w;
  endfunction

  // Offers one word, idling first at the sender's rate, and holds it until accepted.
  task automatic send_word(input arp_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= w.func;
    pkt_len_i    <= w.pkt_len;
    hw_type_i    <= w.hw_type;
    proto_type_i <= w.proto_type;
    arp_op_i     <= w.arp_op;
    sender_mac_i <= w.sender_mac;
    sender_ip_i  <= w.src_ip;
    target_ip_i  <= w.dst_ip;
    query_ip_i   <= w.query_ip;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.predict_outcome(w);
  endtask

  // Lowers valid and waits until every awaited result word has come back; the core is
  // then idle, since each word yields exactly one result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  // One register write; the port is quiet again before the task returns.
  task automatic write_reg(input logic idx, input logic [47:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // One random phase: the registers are set while the core is idle, then the words go
  // out. At hold_at the receiver is asked for its long hold-off, at pause_at the sender
  // waits until every result is back; a negative index means neither happens.
  task automatic run_phase(input int n_words, input int s_pct, input int r_pct,
                           input logic [31:0] ip, input logic [47:0] mac,
                           input int hold_at, input int pause_at);
    drain();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_reg(arpc_pkg::CFG_OWN_IP, {16'd0, ip});
    write_reg(arpc_pkg::CFG_OWN_MAC, mac);
    for (int i = 0; i < n_words; i++) begin
      if (i == hold_at) hold_requested = 1'b1;
      if (i == pause_at) drain();
      send_word(random_word());
    end
  endtask

  // Receiver: checks every accepted result word, then picks the stall for the next
  // cycle. When asked, it holds off for a long stretch so that the result register
  // fills, the single word in flight cannot leave and the input channel stalls.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
        sb.check_outcome({result_kind_o, resolved_mac_o, frame_dest_mac_o, frame_op_o,
                          frame_target_mac_o, frame_target_ip_o});
      if (hold_requested) begin
        hold_requested = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Stimulus: a directed run over the corner cases, then three random phases with
  // different register settings and idling patterns.
  initial begin
    logic [31:0] home_ip;
    logic [31:0] peer_ip;
    logic [31:0] stray_ip;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= arpc_pkg::CFG_OWN_IP;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    func_i       <= arpc_pkg::FUNC_PKT;
    pkt_len_i    <= '0;
    hw_type_i    <= '0;
    proto_type_i <= '0;
    arp_op_i     <= '0;
    sender_mac_i <= '0;
    sender_ip_i  <= '0;
    target_ip_i  <= '0;
    query_ip_i   <= '0;
    hold_requested = 1'b0;
    send_idle_pct  = 20;
    recv_idle_pct  = 73;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    home_ip  = 32'hC0A8_0001;
    peer_ip  = addr_pool[0];
    stray_ip = addr_pool[1];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Queries on the empty table miss and order broadcast requests. own_ip is still
    // zero from reset, so a request for address zero is answered.
    send_word(query_word(32'h0000_0000));
    send_word(query_word(32'hFFFF_FFFF));
    send_word(pkt_word(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                       arpc_pkg::OPCODE_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                       32'h0000_0000));
    drain();
    write_reg(arpc_pkg::CFG_OWN_IP, {16'd0, home_ip});
    write_reg(arpc_pkg::CFG_OWN_MAC, 48'h0200_0000_0001);

    // Packets that fail the length or type checks are dropped and teach nothing.
    send_word(pkt_word(arpc_pkg::ARP_MIN_LEN - 16'd1, arpc_pkg::HW_ETHERNET,
                       arpc_pkg::PROTO_IPV4, arpc_pkg::OPCODE_REQUEST,
                       rand_mac(), stray_ip, home_ip));
    send_word(pkt_word(16'd0, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                       arpc_pkg::OPCODE_REQUEST, rand_mac(), stray_ip, home_ip));
    send_word(pkt_word(arpc_pkg::ARP_MIN_LEN, 16'h0000, arpc_pkg::PROTO_IPV4,
                       arpc_pkg::OPCODE_REQUEST, rand_mac(), stray_ip, home_ip));
    send_word(pkt_word(arpc_pkg::ARP_MIN_LEN, 16'hFFFF, arpc_pkg::PROTO_IPV4,
                       arpc_pkg::OPCODE_REQUEST, rand_mac(), stray_ip, home_ip));
    send_word(pkt_word(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_ETHERNET, 16'h86DD,
                       arpc_pkg::OPCODE_REQUEST, rand_mac(), stray_ip, home_ip));
    send_word(pkt_word(arpc_pkg::ARP_MIN_LEN, arpc_pkg::HW_ETHERNET, 16'hFFFF,
                       arpc_pkg::OPCODE_REQUEST, rand_mac(), stray_ip, home_ip));
    // Longest packet, request for us from address zero with an all-zero MAC.
    send_word(pkt_word(16'hFFFF, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                       arpc_pkg::OPCODE_REQUEST, 48'h0, 32'h0000_0000, home_ip));
    // Request for someone else, reply opcode and odd opcodes: learning only.
    send_word(pkt_word(16'd60, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                       arpc_pkg::OPCODE_REQUEST, rand_mac(), addr_pool[2], addr_pool[3]));
    send_word(pkt_word(16'd60, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, OPCODE_REPLY,
                       rand_mac(), addr_pool[4], home_ip));
    send_word(pkt_word(16'd60, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, 16'h0000,
                       rand_mac(), addr_pool[5], home_ip));
    send_word(pkt_word(16'd60, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, 16'hFFFF,
                       rand_mac(), addr_pool[6], home_ip));
    // Direct add, then a second add of the same address refreshes its MAC.
    send_word(table_word(arpc_pkg::FUNC_ADD, rand_mac(), peer_ip));
    send_word(table_word(arpc_pkg::FUNC_ADD, rand_mac(), peer_ip));
    send_word(query_word(peer_ip));
    send_word(query_word(32'hFFFF_FFFF));
    send_word(query_word(32'h0000_0000));
    // The unused function code must leave the table alone.
    send_word(table_word(arpc_pkg::FUNC_RSVD, rand_mac(), stray_ip));
    send_word(query_word(stray_ip));
    // A request for us from a known sender refreshes the binding and is answered.
    send_word(pkt_word(16'd42, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                       arpc_pkg::OPCODE_REQUEST, rand_mac(), peer_ip, home_ip));
    send_word(query_word(peer_ip));

    run_phase(176, 20, 73, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, -1, -1);
    run_phase(176, 73, 20, 32'h0000_0000, 48'h0, -1, 90);
    run_phase(176, 0, 0, addr_pool[$urandom_range(ADDR_POOL - 1)], rand_mac(), 30, -1);

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    $display("Covered %0d words over %0d register writes: %0d hits, %0d requests,",
             sb.words, sb.reg_writes, sb.hits, sb.requests);
    $display("%0d replies, %0d drops and %0d evictions; %0d mismatches.",
             sb.replies, sb.drops, sb.evictions, sb.errors);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs, with a bound far beyond what a correct run needs.
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hdl/arpc_pkg.sv
hdl/arpc_ctrl.sv
hdl/arpc_dpath.sv
hdl/arp_cache_and_responder_core.sv
tb/testbench.sv
